[design/address_range_symbol_lookup_unit_assert.svh]
// ----------------------------------------------------------------------------
// Address range symbol lookup unit: assertion macros
// Shared concurrent assertion forms, clocked and reset-qualified.
// ----------------------------------------------------------------------------
`ifndef ADDRESS_RANGE_SYMBOL_LOOKUP_UNIT_ASSERT_SVH
`define ADDRESS_RANGE_SYMBOL_LOOKUP_UNIT_ASSERT_SVH

// Same-cycle implication
`define ARSL_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication
`define ARSL_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

[design/arsl_pkg.sv]
// ----------------------------------------------------------------------------
// Address range symbol lookup package
// Shared types, codes and control/status bundles.
// ----------------------------------------------------------------------------
`default_nettype none

package arsl_pkg;

   // Symbol type filter
   localparam logic [3:0] TYPE_MASK   = 4'hF;
   localparam logic [3:0] TYPE_FUNC   = 4'd1;
   localparam logic [3:0] TYPE_OBJECT = 4'd2;

   typedef enum logic [1:0] {
      MODE_CLEAR  = 2'd0,
      MODE_INSERT = 2'd1,
      MODE_LOOKUP = 2'd2,
      MODE_NOP    = 2'd3
   } mode_type;

   typedef enum logic [1:0] {
      ST_DONE     = 2'd0,
      ST_FULL     = 2'd1,
      ST_FILTERED = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      RD_MID,
      RD_PRED,
      RD_PTR
   } rd_sel_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_DECODE,
      S_SRCH_RD,
      S_SRCH_CMP,
      S_FETCH_RD,
      S_FETCH_CHK,
      S_SHIFT_RD,
      S_SHIFT_WR,
      S_PUT,
      S_FINISH
   } state_type;

   typedef struct packed {
      logic [31:0] start;
      logic [31:0] size;
      logic [23:0] handle;
   } entry_type;

   typedef struct packed {
      logic       capture;
      logic       clear;
      logic       set_status;
      status_type status;
      logic       init_search;
      logic       srch_upd;
      rd_sel_type rd_sel;
      logic       check;
      logic       ptr_load;
      logic       ptr_dec;
      logic       wr_shift;
      logic       wr_new;
      logic       emit;
   } cmd_type;

   typedef struct packed {
      mode_type mode;
      logic     filtered;
      logic     full;
      logic     lo_lt_hi;
      logic     lo_zero;
      logic     count_gt_lo;
      logic     shift_last;
      logic     out_free;
   } stat_type;

endpackage

`default_nettype wire

[design/address_range_symbol_lookup_unit.sv]
// ----------------------------------------------------------------------------
// Address range symbol lookup unit
// Sorted symbol table with binary-search address-to-symbol lookup.
// ----------------------------------------------------------------------------
// One command at a time. Clear, unused mode and rejected inserts go from the
// decode state straight to the result stage. Lookup runs binary-search steps (up
// to ceil(log2(n+1)) steps for n held entries), then reads the predecessor entry
// and checks whether it covers the query; that read is skipped when no held start
// lies at or below the query. Insert runs the same search, then moves each entry
// from the found slot up by one to open the slot, and writes the new entry. The
// search and the shift both run through the single read port of the entry
// memory, whose read data is registered, so each step is one read then one
// compare or write. The entry memory is never cleared; only entries below the
// held count are ever used, so no clearing pass runs after reset. A finished
// result sits in an output register and the next command is taken while it
// waits.
`default_nettype none

module address_range_symbol_lookup_unit #(
   parameter int TABLE_DEPTH = 256
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [1:0]  req_mode,
   input  wire logic [31:0] req_addr,
   input  wire logic [31:0] req_size,
   input  wire logic [7:0]  req_sym_type,
   input  wire logic [23:0] req_name_ref,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic             rsp_hit,
   output logic [31:0]      rsp_found_addr,
   output logic [31:0]      rsp_found_size,
   output logic [31:0]      rsp_byte_offset,
   output logic [23:0]      rsp_found_name_ref,
   output logic [1:0]       rsp_status,
   output logic [8:0]       rsp_entry_count
);
   import arsl_pkg::*;

   cmd_type  cmd;
   stat_type stat;

   // Sequencer
   arsl_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   // Table and result path
   arsl_dp #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_dp (
      .clock              (clock),
      .reset              (reset),
      .req_mode           (req_mode),
      .req_addr           (req_addr),
      .req_size           (req_size),
      .req_sym_type       (req_sym_type),
      .req_name_ref       (req_name_ref),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_hit            (rsp_hit),
      .rsp_found_addr     (rsp_found_addr),
      .rsp_found_size     (rsp_found_size),
      .rsp_byte_offset    (rsp_byte_offset),
      .rsp_found_name_ref (rsp_found_name_ref),
      .rsp_status         (rsp_status),
      .rsp_entry_count    (rsp_entry_count),
      .cmd                (cmd),
      .stat               (stat)
   );

endmodule

`default_nettype wire

[design/arsl_ctrl.sv]
// ----------------------------------------------------------------------------
// Address range symbol lookup controller
// Sequences search, shift, write and result hand-off for one item at a time.
// ----------------------------------------------------------------------------
`default_nettype none

module arsl_ctrl (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire arsl_pkg::stat_type stat,
   output arsl_pkg::cmd_type      cmd
);
   import arsl_pkg::*;

   state_type state_ff, state_in;

   // State register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state and commands
   always_comb begin
      state_in  = state_ff;
      req_ready = 1'b0;
      cmd       = '0;
      cmd.rd_sel = RD_MID;
      cmd.status = ST_DONE;
      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = S_DECODE;
            end
         end
         S_DECODE: begin
            case (stat.mode)
               MODE_CLEAR: begin
                  cmd.clear = 1'b1;
                  state_in  = S_FINISH;
               end
               MODE_INSERT: begin
                  if (stat.filtered) begin
                     cmd.set_status = 1'b1;
                     cmd.status     = ST_FILTERED;
                     state_in       = S_FINISH;
                  end else if (stat.full) begin
                     cmd.set_status = 1'b1;
                     cmd.status     = ST_FULL;
                     state_in       = S_FINISH;
                  end else begin
                     cmd.init_search = 1'b1;
                     state_in        = S_SRCH_RD;
                  end
               end
               MODE_LOOKUP: begin
                  cmd.init_search = 1'b1;
                  state_in        = S_SRCH_RD;
               end
               default: begin
                  state_in = S_FINISH;
               end
            endcase
         end
         S_SRCH_RD: begin
            cmd.rd_sel = RD_MID;
            if (stat.lo_lt_hi) begin
               state_in = S_SRCH_CMP;
            end else if (stat.mode == MODE_LOOKUP) begin
               state_in = stat.lo_zero ? S_FINISH : S_FETCH_RD;
            end else if (stat.count_gt_lo) begin
               cmd.ptr_load = 1'b1;
               state_in     = S_SHIFT_RD;
            end else begin
               state_in = S_PUT;
            end
         end
         S_SRCH_CMP: begin
            cmd.srch_upd = 1'b1;
            state_in     = S_SRCH_RD;
         end
         S_FETCH_RD: begin
            cmd.rd_sel = RD_PRED;
            state_in   = S_FETCH_CHK;
         end
         S_FETCH_CHK: begin
            cmd.check = 1'b1;
            state_in  = S_FINISH;
         end
         S_SHIFT_RD: begin
            cmd.rd_sel = RD_PTR;
            state_in   = S_SHIFT_WR;
         end
         S_SHIFT_WR: begin
            cmd.wr_shift = 1'b1;
            if (stat.shift_last) begin
               state_in = S_PUT;
            end else begin
               cmd.ptr_dec = 1'b1;
               state_in    = S_SHIFT_RD;
            end
         end
         S_PUT: begin
            cmd.wr_new = 1'b1;
            state_in   = S_FINISH;
         end
         S_FINISH: begin
            if (stat.out_free) begin
               cmd.emit = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

endmodule

`default_nettype wire

[design/arsl_dp.sv]
// ----------------------------------------------------------------------------
// Address range symbol lookup datapath
// Entry memory, search bounds, shift pointer, entry count and result beat.
// ----------------------------------------------------------------------------
`default_nettype none
`include "address_range_symbol_lookup_unit_assert.svh"

module arsl_dp #(
   parameter int TABLE_DEPTH = 256
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic [1:0]        req_mode,
   input  wire logic [31:0]       req_addr,
   input  wire logic [31:0]       req_size,
   input  wire logic [7:0]        req_sym_type,
   input  wire logic [23:0]       req_name_ref,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output logic                   rsp_hit,
   output logic [31:0]            rsp_found_addr,
   output logic [31:0]            rsp_found_size,
   output logic [31:0]            rsp_byte_offset,
   output logic [23:0]            rsp_found_name_ref,
   output logic [1:0]             rsp_status,
   output logic [8:0]             rsp_entry_count,
   input  wire arsl_pkg::cmd_type cmd,
   output arsl_pkg::stat_type     stat
);
   import arsl_pkg::*;

   localparam int IDX_W = $clog2(TABLE_DEPTH);
   localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

   // Item registers
   mode_type    op_mode_ff;
   logic [31:0] key_ff;
   logic [31:0] new_size_ff;
   logic [23:0] new_name_ff;
   logic        filtered_ff;

   // Table control
   logic [CNT_W-1:0] count_ff;
   logic [CNT_W-1:0] lo_ff;
   logic [CNT_W-1:0] hi_ff;
   logic [IDX_W-1:0] ptr_ff;

   // Entry memory
   entry_type entry_mem [TABLE_DEPTH];
   entry_type rd_data_ff;

   // Result staging
   logic        res_hit_ff;
   entry_type   res_entry_ff;
   logic [31:0] res_off_ff;
   status_type  res_status_ff;

   // Result beat
   logic        rsp_valid_ff;
   logic        rsp_hit_ff;
   logic [31:0] rsp_addr_ff;
   logic [31:0] rsp_size_ff;
   logic [31:0] rsp_off_ff;
   logic [23:0] rsp_name_ff;
   status_type  rsp_status_ff;
   logic [8:0]  rsp_count_ff;

   logic [CNT_W-1:0] diff;
   logic [CNT_W-1:0] mid;
   logic [CNT_W-1:0] pred;
   logic [CNT_W-1:0] cnt_m1;
   logic [IDX_W-1:0] lo_idx;
   logic [IDX_W-1:0] rd_addr;
   logic [IDX_W-1:0] wr_addr;
   entry_type        wr_data;
   logic             mem_we;
   logic [31:0]      off;
   logic             covered;
   logic [3:0]       type_lo;

   // Search midpoint, predecessor and addresses
   always_comb begin
      diff    = hi_ff - lo_ff;
      mid     = lo_ff + (diff >> 1);
      pred    = lo_ff - CNT_W'(1);
      cnt_m1  = count_ff - CNT_W'(1);
      lo_idx  = lo_ff[IDX_W-1:0];
      case (cmd.rd_sel)
         RD_MID:  rd_addr = mid[IDX_W-1:0];
         RD_PRED: rd_addr = pred[IDX_W-1:0];
         RD_PTR:  rd_addr = ptr_ff;
         default: rd_addr = mid[IDX_W-1:0];
      endcase
      mem_we  = cmd.wr_shift | cmd.wr_new;
      wr_addr = cmd.wr_shift ? (ptr_ff + IDX_W'(1)) : lo_idx;
      wr_data = cmd.wr_shift ? rd_data_ff : entry_type'{start: key_ff, size: new_size_ff,
                                                        handle: new_name_ff};
      off     = key_ff - rd_data_ff.start;
      covered = (rd_data_ff.size == 32'd0) || (off < rd_data_ff.size);
      type_lo = req_sym_type[3:0] & TYPE_MASK;
   end

   // Status to the controller
   always_comb begin
      stat.mode        = op_mode_ff;
      stat.filtered    = filtered_ff;
      stat.full        = (count_ff >= CNT_W'(TABLE_DEPTH));
      stat.lo_lt_hi    = (lo_ff < hi_ff);
      stat.lo_zero     = (lo_ff == '0);
      stat.count_gt_lo = (count_ff > lo_ff);
      stat.shift_last  = (ptr_ff == lo_idx);
      stat.out_free    = !rsp_valid_ff || rsp_ready;
   end

   // Entry memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (mem_we) begin
         entry_mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= entry_mem[rd_addr];
   end

   // Capture the item and prefilter inserts
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_mode_ff  <= mode_type'(req_mode);
         key_ff      <= req_addr;
         new_size_ff <= req_size;
         new_name_ff <= req_name_ref;
         filtered_ff <= !((type_lo == TYPE_FUNC) || (type_lo == TYPE_OBJECT))
                        || (req_addr == 32'd0);
      end
   end

   // Entry count
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (cmd.clear) begin
         count_ff <= '0;
      end else if (cmd.wr_new) begin
         count_ff <= count_ff + CNT_W'(1);
      end
   end

   // Search bounds and shift pointer
   always_ff @(posedge clock) begin
      if (cmd.init_search) begin
         lo_ff <= '0;
         hi_ff <= count_ff;
      end else if (cmd.srch_upd) begin
         if (rd_data_ff.start <= key_ff) begin
            lo_ff <= mid + CNT_W'(1);
         end else begin
            hi_ff <= mid;
         end
      end
      if (cmd.ptr_load) begin
         ptr_ff <= cnt_m1[IDX_W-1:0];
      end else if (cmd.ptr_dec) begin
         ptr_ff <= ptr_ff - IDX_W'(1);
      end
   end

   // Result staging: zero on capture, fill on a covering entry
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         res_hit_ff    <= 1'b0;
         res_entry_ff  <= '0;
         res_off_ff    <= '0;
         res_status_ff <= ST_DONE;
      end else begin
         if (cmd.set_status) begin
            res_status_ff <= cmd.status;
         end
         if (cmd.check && covered) begin
            res_hit_ff   <= 1'b1;
            res_entry_ff <= rd_data_ff;
            res_off_ff   <= off;
         end
      end
   end

   // Result beat: hold until taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         rsp_hit_ff    <= res_hit_ff;
         rsp_addr_ff   <= res_entry_ff.start;
         rsp_size_ff   <= res_entry_ff.size;
         rsp_off_ff    <= res_off_ff;
         rsp_name_ff   <= res_entry_ff.handle;
         rsp_status_ff <= res_status_ff;
         rsp_count_ff  <= 9'(count_ff);
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_hit            = rsp_hit_ff;
   assign rsp_found_addr     = rsp_addr_ff;
   assign rsp_found_size     = rsp_size_ff;
   assign rsp_byte_offset    = rsp_off_ff;
   assign rsp_found_name_ref = rsp_name_ff;
   assign rsp_status         = rsp_status_ff;
   assign rsp_entry_count    = rsp_count_ff;

   // Checks
   `ARSL_ASSERT_IMP(a_count_bound, clock, reset, 1'b1,
      count_ff <= CNT_W'(TABLE_DEPTH), "entry count above table depth")
   `ARSL_ASSERT_NXT(a_put_grows, clock, reset, cmd.wr_new,
      count_ff == $past(count_ff) + CNT_W'(1), "insert did not grow the table")
   `ARSL_ASSERT_IMP(a_hit_done, clock, reset, rsp_valid_ff && rsp_hit_ff,
      rsp_status_ff == ST_DONE, "hit beat carries an error status")

endmodule

`default_nettype wire
